// ----- hw/rtl/bafd_pkg.sv -----
package bafd_pkg;

   localparam int LEVEL_W   = 16;
   localparam int SAMPLE_W  = 12;
   localparam int STEP_W    = 8;
   localparam int CMD_W     = 2;
   localparam int AVG_SHIFT = 4;

   // reciprocal divider widths: a 16-bit sum times a 17-bit reciprocal
   localparam int RECIP_W = LEVEL_W + 1;
   localparam int PROD_W  = LEVEL_W + RECIP_W;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_SEL_W  = 3;

   localparam logic [LEVEL_W-1:0] DWELL_MAX  = '1;
   localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE   = 2'd0,
      CMD_CHECK    = 2'd1,
      CMD_SET_STEP = 2'd2,
      CMD_NOP      = 2'd3
   } cmd_type;

   typedef enum logic [REG_SEL_W-1:0] {
      REG_FULL_MIN_LEVEL = 3'd0,
      REG_UPPER_LEVEL    = 3'd1,
      REG_LOWER_LEVEL    = 3'd2,
      REG_UPPER_WAIT     = 3'd3,
      REG_LOWER_WAIT     = 3'd4
   } reg_sel_type;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [SAMPLE_W-1:0] sample;
      logic                charger_present;
      logic [STEP_W-1:0]   step_value;
   } req_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] average_level;
      logic               full_done;
      logic [STEP_W-1:0]  dwell_step;
   } rsp_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] full_min_level;
      logic [LEVEL_W-1:0] upper_level;
      logic [LEVEL_W-1:0] lower_level;
      logic [LEVEL_W-1:0] upper_wait;
      logic [LEVEL_W-1:0] lower_wait;
   } cfg_type;

endpackage

// ----- hw/rtl/bafd_csr.sv -----
module bafd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bafd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bafd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bafd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output bafd_pkg::cfg_type                  cfg
);
   import bafd_pkg::*;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   reg_sel_type      sel;
   logic             wr_en;
   logic [LEVEL_W-1:0] wr_val;
   logic [LEVEL_W-1:0] rd_val;

   assign sel    = reg_sel_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign wr_val = pwdata[LEVEL_W-1:0];
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sel)
            REG_FULL_MIN_LEVEL: cfg_in.full_min_level = wr_val;
            REG_UPPER_LEVEL:    cfg_in.upper_level    = wr_val;
            REG_LOWER_LEVEL:    cfg_in.lower_level    = wr_val;
            REG_UPPER_WAIT:     cfg_in.upper_wait     = wr_val;
            REG_LOWER_WAIT:     cfg_in.lower_wait     = wr_val;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_FULL_MIN_LEVEL: rd_val = cfg_ff.full_min_level;
         REG_UPPER_LEVEL:    rd_val = cfg_ff.upper_level;
         REG_LOWER_LEVEL:    rd_val = cfg_ff.lower_level;
         REG_UPPER_WAIT:     rd_val = cfg_ff.upper_wait;
         REG_LOWER_WAIT:     rd_val = cfg_ff.lower_wait;
         default:            rd_val = '0;
      endcase
   end

   assign prdata = CSR_DATA_W'(rd_val);
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/bafd_in_reg.sv -----
module bafd_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bafd_pkg::req_word_type req_data,
   output logic                   stage_valid,
   output bafd_pkg::req_word_type stage_data,
   input  logic                   stage_take
);
   import bafd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type data_ff;

   // stage is free when empty or drained this cycle
   assign req_ready   = !valid_ff || stage_take;
   assign valid_in    = req_valid || (valid_ff && !stage_take);
   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= req_ready ? req_valid : valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

// ----- hw/rtl/bafd_update.sv -----
module bafd_update #(
   parameter int AVG_SAMPLES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bafd_pkg::cfg_type      cfg,
   input  logic                   stage_valid,
   input  bafd_pkg::req_word_type stage_data,
   output logic                   stage_take,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bafd_pkg::rsp_word_type rsp_data
);
   import bafd_pkg::*;

   localparam int CNT_W     = $clog2(AVG_SAMPLES + 1);
   localparam int DIV_SHIFT = LEVEL_W + $clog2(AVG_SAMPLES);
   localparam int RECIP     = ((1 << DIV_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES;

   function automatic logic [LEVEL_W-1:0] sat_add(input logic [LEVEL_W-1:0] a,
                                                  input logic [STEP_W-1:0]  b);
      logic [LEVEL_W:0] s;
      s = {1'b0, a} + (LEVEL_W + 1)'(b);
      return s[LEVEL_W] ? DWELL_MAX : s[LEVEL_W-1:0];
   endfunction

   logic [LEVEL_W-1:0] sum_ff,   sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LEVEL_W-1:0] avg_ff,   avg_in;
   logic [LEVEL_W-1:0] lo_dw_ff, lo_dw_in;
   logic [LEVEL_W-1:0] up_dw_ff, up_dw_in;
   logic               done_ff,  done_in;
   logic [STEP_W-1:0]  step_ff,  step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_data_ff;

   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]  quot;
   logic [LEVEL_W-1:0] block_avg;

   // sum / AVG_SAMPLES via exact reciprocal multiply
   assign recip     = RECIP_W'(RECIP);
   assign prod      = PROD_W'(sum_ff) * PROD_W'(recip);
   assign quot      = prod >> DIV_SHIFT;
   assign block_avg = {quot[LEVEL_W-AVG_SHIFT-1:0], {AVG_SHIFT{1'b0}}};

   assign stage_take = stage_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      avg_in   = avg_ff;
      lo_dw_in = lo_dw_ff;
      up_dw_in = up_dw_ff;
      done_in  = done_ff;
      step_in  = step_ff;
      if (stage_take) begin
         case (cmd_type'(stage_data.cmd))
            CMD_SAMPLE: begin
               if (count_ff < CNT_W'(AVG_SAMPLES)) begin
                  sum_in   = sum_ff + LEVEL_W'(stage_data.sample);
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  avg_in   = block_avg;
                  sum_in   = '0;
                  count_in = '0;
               end
            end
            CMD_CHECK: begin
               if (!stage_data.charger_present) begin
                  if (avg_ff < cfg.full_min_level) begin
                     step_in  = STEP_RESET;
                     lo_dw_in = '0;
                     up_dw_in = '0;
                     done_in  = 1'b0;
                  end
               end else if (avg_ff > cfg.upper_level) begin
                  if (up_dw_ff < cfg.upper_wait) begin
                     up_dw_in = sat_add(up_dw_ff, step_ff);
                     done_in  = 1'b0;
                  end else begin
                     done_in  = 1'b1;
                  end
               end else if (avg_ff > cfg.lower_level) begin
                  if (lo_dw_ff < cfg.lower_wait) begin
                     lo_dw_in = sat_add(lo_dw_ff, step_ff);
                     done_in  = 1'b0;
                  end else begin
                     done_in  = 1'b1;
                  end
               end else begin
                  lo_dw_in = '0;
                  up_dw_in = '0;
                  done_in  = 1'b0;
               end
            end
            CMD_SET_STEP: step_in = stage_data.step_value;
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = stage_take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         avg_ff       <= '0;
         lo_dw_ff     <= '0;
         up_dw_ff     <= '0;
         done_ff      <= 1'b0;
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         avg_ff       <= avg_in;
         lo_dw_ff     <= lo_dw_in;
         up_dw_ff     <= up_dw_in;
         done_ff      <= done_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take) begin
         rsp_data_ff.average_level <= avg_in;
         rsp_data_ff.full_done     <= done_in;
         rsp_data_ff.dwell_step    <= step_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/battery_average_and_full_detect_core.sv -----
// battery average and full detect: each request word carries one command.
// a sample command adds a 12-bit adc reading to a running sum; once
// AVG_SAMPLES readings are in, the next sample command drops its reading,
// stores (sum / AVG_SAMPLES) << 4 as the average and restarts the sum. a
// check command with the charger present compares the average with the
// upper and lower levels and advances the matching dwell counter by the
// dwell step, saturating at 65535, and raises full_done once the counter
// has reached its wait; at or below the lower level the counters and done
// flag clear. with the charger absent and the average below full_min_level
// the step returns to 1 and the counters and done flag clear. a set command
// loads the step. every request word, whatever its command, yields exactly
// one response word holding the updated average, done flag and step. the
// block takes one word per clock unless the response side stalls; a word
// moves from the input register through the single state update stage
// into the response register. the user must write thresholds and waits
// over the apb port only while idle; the block does not enforce this.
module battery_average_and_full_detect_core #(
   parameter int AVG_SAMPLES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bafd_pkg::req_word_type          req_data,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bafd_pkg::rsp_word_type          rsp_data,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bafd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bafd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bafd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import bafd_pkg::*;

   cfg_type      cfg;
   logic         stage_valid;
   logic         stage_take;
   req_word_type stage_data;

   // threshold and wait registers
   bafd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register; when it is full, req_ready depends on the response side
   bafd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .stage_take  (stage_take)
   );

   // averaging and dwell state, response register
   bafd_update #(
      .AVG_SAMPLES (AVG_SAMPLES)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .stage_take  (stage_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- hw/rtl/bafd_checker.sv -----
module bafd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input bafd_pkg::rsp_word_type          rsp_data,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [bafd_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [bafd_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [bafd_pkg::CSR_DATA_W-1:0] prdata
);
   import bafd_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // with the response side empty the input never pushes back
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty response register");

   // full_min_level reads back the value last written to it
   a_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && paddr == CSR_ADDR_W'(0) ##1 paddr == CSR_ADDR_W'(0)
      |-> prdata[LEVEL_W-1:0] == $past(pwdata[LEVEL_W-1:0]))
      else $error("full_min_level readback mismatch");

   // registers are 16 bits, upper read bits stay zero
   a_rd_upper_zero: assert property (@(posedge clock) disable iff (reset)
      prdata[CSR_DATA_W-1:LEVEL_W] == '0)
      else $error("nonzero upper read data");

   // response valid is cleared by reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind battery_average_and_full_detect_core bafd_checker u_bafd_checker (.*);
